@@ hw/rtl/hpd_pkg.sv @@
// Shared types, codes and constants for the heartbeat peak detector.
package hpd_pkg;

    localparam int INTERVAL_W    = 12;
    localparam int ELAPSED_W     = 16;
    localparam int BPM_W         = 8;
    localparam int MS_PER_MINUTE = 60000;
    localparam int MAX_INTERVAL  = 4095;
    localparam int BPM_MAX       = 255;

    // reset values of the detector state and config registers
    localparam int LEVEL_RESET      = 512;
    localparam int INTERVAL_RESET   = 600;
    localparam int TICK_RESET       = 2;
    localparam int REFRACTORY_RESET = 250;
    localparam int TIMEOUT_RESET    = 2500;

    // (x / 5) * 3 via reciprocal 3277 / 2^14, exact for 12-bit x
    localparam int RECIP5      = 3277;
    localparam int RECIP5_SH   = 14;
    localparam int DICR_RESET  = (INTERVAL_RESET / 5) * 3;

    typedef enum logic [1:0] {
        REG_TICK_MS       = 2'd0,
        REG_IDLE_LEVEL    = 2'd1,
        REG_REFRACTORY_MS = 2'd2,
        REG_TIMEOUT_MS    = 2'd3
    } cfg_reg_t;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_STEP = 5'b00010,
        S_AVG  = 5'b00100,
        S_BPM  = 5'b01000,
        S_LOAD = 5'b10000
    } state_t;

    function automatic logic [INTERVAL_W-1:0] dicrotic_limit(
        input logic [INTERVAL_W-1:0] ival
    );
        logic [2*INTERVAL_W-1:0] prod;
        logic [INTERVAL_W-1:0]   q5;
        prod = (2*INTERVAL_W)'(ival) * (2*INTERVAL_W)'(RECIP5);
        q5   = INTERVAL_W'(prod >> RECIP5_SH);
        return INTERVAL_W'(q5 + (q5 << 1));
    endfunction

endpackage

@@ hw/rtl/heartbeat_peak_detector_unit.sv @@
// Heartbeat peak detector: adaptive-threshold beat detection with averaged BPM.
// Path, input word accepted to result word valid: S_STEP then S_LOAD with no beat or a first
// beat, S_STEP, S_BPM, S_LOAD for the second beat, S_STEP, S_AVG, S_BPM, S_LOAD for later beats.
// S_BPM steps the DIV_W-bit divider (DIV_W 16 by default). One word in flight; the next input
// word is taken the cycle after the result registers, in S_LOAD once the result side is open.
// Reset: synchronous, active low; config to defaults, detector idle, interval history unset.
module heartbeat_peak_detector_unit #(
    parameter int AVG_DEPTH   = 10,
    parameter int SAMPLE_BITS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    // sample input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] sample, [15:12] zero
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] bpm, [8] bpm_updated, [9] in_pulse,
                                   // [21:10] interval_ms, [33:22] threshold_now, [39:34] zero
    // config writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int LW     = SAMPLE_BITS;
    localparam int IW     = hpd_pkg::INTERVAL_W;
    localparam int EW     = hpd_pkg::ELAPSED_W;
    localparam int SUM_W  = IW + $clog2(AVG_DEPTH);
    localparam int DIV_W  = (SUM_W > 16) ? SUM_W : 16;
    localparam int CNT_W  = $clog2(DIV_W);
    localparam int OUT_W  = 40;

    // sum / AVG_DEPTH as (sum * AVG_RECIP) >> AVG_SH, exact for any SUM_W-bit sum
    localparam int AVG_SH    = SUM_W + 4;
    localparam int AVG_RECIP = ((1 << AVG_SH) + AVG_DEPTH - 1) / AVG_DEPTH;
    localparam int PROD_W    = SUM_W + AVG_SH;

    // ---------------- config registers ----------------
    logic [7:0]    tick_reg;
    logic [11:0]   idle_reg;
    logic [11:0]   refr_reg;
    logic [15:0]   tmo_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg <= 8'(hpd_pkg::TICK_RESET);
            idle_reg <= 12'(hpd_pkg::LEVEL_RESET);
            refr_reg <= 12'(hpd_pkg::REFRACTORY_RESET);
            tmo_reg  <= 16'(hpd_pkg::TIMEOUT_RESET);
        end else if (cfg_valid) begin
            case (hpd_pkg::cfg_reg_t'(cfg_index))
                hpd_pkg::REG_TICK_MS:       tick_reg <= cfg_data[7:0];
                hpd_pkg::REG_IDLE_LEVEL:    idle_reg <= cfg_data[11:0];
                hpd_pkg::REG_REFRACTORY_MS: refr_reg <= cfg_data[11:0];
                hpd_pkg::REG_TIMEOUT_MS:    tmo_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- state ----------------
    hpd_pkg::state_t state_reg, state_next;

    logic [LW-1:0]   samp_reg, samp_next;
    logic [EW-1:0]   elapsed_reg, elapsed_next;
    logic [IW-1:0]   ival_reg, ival_next;      // last inter-beat interval
    logic [IW-1:0]   dicr_reg;                 // (ival / 5) * 3, follows ival_reg
    logic [LW-1:0]   peak_reg, peak_next;
    logic [LW-1:0]   trough_reg, trough_next;
    logic [LW-1:0]   thr_reg, thr_next;
    logic            active_reg, active_next;  // inside a beat
    logic            first_reg, first_next;    // waiting for first beat
    logic            second_reg, second_next;  // next beat seeds the history
    logic [7:0]      bpm_reg, bpm_next;
    logic            upd_reg, upd_next;

    // interval history (shift line, oldest at index 0) and its running sum
    logic [IW-1:0]   hist_reg [AVG_DEPTH];
    logic            hist_fill, hist_shift;
    logic [SUM_W-1:0] sum_reg, sum_next;

    // shared restoring divider
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // output register
    logic             m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0] m_tdata_reg, m_tdata_next;

    assign s_tready = (state_reg == hpd_pkg::S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------- per-tick detector logic ----------------
    logic [EW:0]     age_sum;
    logic [EW-1:0]   age;
    logic [IW-1:0]   ival_sat;
    logic            past_dicr, s_lt, s_gt, beat, first_beat, falling, timed_out;
    logic [LW-1:0]   trough_up, peak_up, amp, thr_fall;
    logic [SUM_W-1:0] sum_calc;

    always_comb begin
        age_sum   = {1'b0, elapsed_reg} + (EW+1)'(tick_reg);
        age       = age_sum[EW] ? {EW{1'b1}} : age_sum[EW-1:0];
        ival_sat  = (age > EW'(hpd_pkg::MAX_INTERVAL)) ? {IW{1'b1}} : age[IW-1:0];
        past_dicr = age > EW'(dicr_reg);
        s_lt      = samp_reg < thr_reg;
        s_gt      = samp_reg > thr_reg;
        beat       = (age > EW'(refr_reg)) && s_gt && !active_reg && past_dicr;
        first_beat = beat && first_reg;
        trough_up = (s_lt && past_dicr && (samp_reg < trough_reg)) ? samp_reg : trough_reg;
        peak_up   = (s_gt && (samp_reg > peak_reg)) ? samp_reg : peak_reg;
        // first-beat tick skips the falling edge and timeout handling
        falling   = !first_beat && s_lt && active_reg;
        amp       = peak_up - trough_up;
        thr_fall  = (amp >> 1) + trough_up;
        timed_out = !first_beat && (age > tmo_reg);
        if (second_reg) begin
            sum_calc = SUM_W'(ival_sat) * SUM_W'(AVG_DEPTH);
        end else begin
            sum_calc = sum_reg - SUM_W'(hist_reg[0]) + SUM_W'(ival_sat);
        end
    end

    // average interval from the registered running sum
    logic [PROD_W-1:0] avg_prod;
    logic [IW-1:0]     avg_q;

    always_comb begin
        avg_prod = PROD_W'(sum_reg) * PROD_W'(AVG_RECIP);
        avg_q    = IW'(avg_prod >> AVG_SH);
    end

    // one divider step: shift in next dividend bit, trial subtract
    logic [DIV_W:0]   div_shift;
    logic             div_ge;
    logic [DIV_W-1:0] rem_step, quo_step;
    logic             div_last;

    always_comb begin
        div_shift = {rem_reg, quo_reg[DIV_W-1]};
        div_ge    = div_shift >= {1'b0, dvs_reg};
        rem_step  = div_ge ? DIV_W'(div_shift - {1'b0, dvs_reg}) : div_shift[DIV_W-1:0];
        quo_step  = {quo_reg[DIV_W-2:0], div_ge};
        div_last  = (cnt_reg == CNT_W'(DIV_W - 1));
    end

    // ---------------- sequencer ----------------
    always_comb begin
        state_next    = state_reg;
        samp_next     = samp_reg;
        elapsed_next  = elapsed_reg;
        ival_next     = ival_reg;
        peak_next     = peak_reg;
        trough_next   = trough_reg;
        thr_next      = thr_reg;
        active_next   = active_reg;
        first_next    = first_reg;
        second_next   = second_reg;
        bpm_next      = bpm_reg;
        upd_next      = upd_reg;
        sum_next      = sum_reg;
        hist_fill     = 1'b0;
        hist_shift    = 1'b0;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        dvs_next      = dvs_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        case (state_reg)
            hpd_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    samp_next  = LW'(s_tdata[11:0]);
                    state_next = hpd_pkg::S_STEP;
                end
            end

            hpd_pkg::S_STEP: begin
                elapsed_next = age;
                trough_next  = trough_up;
                peak_next    = peak_up;
                upd_next     = 1'b0;
                cnt_next     = '0;
                state_next   = hpd_pkg::S_LOAD;
                if (beat) begin
                    active_next  = 1'b1;
                    ival_next    = ival_sat;
                    elapsed_next = '0;
                    if (first_reg) begin
                        // first beat only marks the time
                        first_next  = 1'b0;
                        second_next = 1'b1;
                    end else begin
                        second_next = 1'b0;
                        sum_next    = sum_calc;
                        hist_fill   = second_reg;
                        hist_shift  = !second_reg;
                        rem_next    = '0;
                        if (second_reg) begin
                            // history is uniform, average is the interval itself
                            quo_next   = DIV_W'(hpd_pkg::MS_PER_MINUTE);
                            dvs_next   = DIV_W'(ival_sat);
                            state_next = hpd_pkg::S_BPM;
                        end else begin
                            state_next = hpd_pkg::S_AVG;
                        end
                    end
                end
                if (falling) begin
                    active_next = 1'b0;
                    thr_next    = thr_fall;
                    peak_next   = thr_fall;
                    trough_next = thr_fall;
                end
                if (timed_out) begin
                    thr_next     = LW'(idle_reg);
                    peak_next    = LW'(idle_reg);
                    trough_next  = LW'(idle_reg);
                    elapsed_next = '0;
                    first_next   = 1'b1;
                    second_next  = 1'b0;
                end
            end

            hpd_pkg::S_AVG: begin
                // average by reciprocal multiply, then set up 60000 / average
                rem_next   = '0;
                quo_next   = DIV_W'(hpd_pkg::MS_PER_MINUTE);
                dvs_next   = DIV_W'(avg_q);
                cnt_next   = '0;
                state_next = hpd_pkg::S_BPM;
            end

            hpd_pkg::S_BPM: begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg + 1'b1;
                if (div_last) begin
                    // zero average divides to all ones, which saturates too
                    bpm_next   = (quo_step > DIV_W'(hpd_pkg::BPM_MAX)) ?
                                 8'(hpd_pkg::BPM_MAX) : quo_step[7:0];
                    upd_next   = 1'b1;
                    state_next = hpd_pkg::S_LOAD;
                end
            end

            hpd_pkg::S_LOAD: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'd0, 12'(thr_reg), ival_reg, active_reg,
                                     upd_reg, bpm_reg};
                    state_next    = hpd_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = hpd_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= hpd_pkg::S_IDLE;
            elapsed_reg  <= '0;
            ival_reg     <= IW'(hpd_pkg::INTERVAL_RESET);
            dicr_reg     <= IW'(hpd_pkg::DICR_RESET);
            peak_reg     <= LW'(hpd_pkg::LEVEL_RESET);
            trough_reg   <= LW'(hpd_pkg::LEVEL_RESET);
            thr_reg      <= LW'(hpd_pkg::LEVEL_RESET);
            active_reg   <= 1'b0;
            first_reg    <= 1'b1;
            second_reg   <= 1'b1;
            bpm_reg      <= '0;
            upd_reg      <= 1'b0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            elapsed_reg  <= elapsed_next;
            ival_reg     <= ival_next;
            dicr_reg     <= hpd_pkg::dicrotic_limit(ival_reg);
            peak_reg     <= peak_next;
            trough_reg   <= trough_next;
            thr_reg      <= thr_next;
            active_reg   <= active_next;
            first_reg    <= first_next;
            second_reg   <= second_next;
            bpm_reg      <= bpm_next;
            upd_reg      <= upd_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        samp_reg    <= samp_next;
        sum_reg     <= sum_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        dvs_reg     <= dvs_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_ff @(posedge aclk) begin
        if (hist_fill) begin
            for (int i = 0; i < AVG_DEPTH; i++) begin
                hist_reg[i] <= ival_sat;
            end
        end else if (hist_shift) begin
            for (int i = 0; i < AVG_DEPTH - 1; i++) begin
                hist_reg[i] <= hist_reg[i+1];
            end
            hist_reg[AVG_DEPTH-1] <= ival_sat;
        end
    end

    // ---------------- assertions ----------------
    a_accept_to_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == hpd_pkg::S_STEP))
        else $error("accepted word did not start a detector step");

    a_div_starts_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == hpd_pkg::S_STEP) |=> (cnt_reg == '0))
        else $error("divider count not cleared at start of division");

    a_valid_from_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == hpd_pkg::S_LOAD))
        else $error("result valid raised outside the load state");

    a_update_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == hpd_pkg::S_LOAD && upd_reg) |-> $past(upd_reg) ||
        $past(state_reg == hpd_pkg::S_BPM))
        else $error("bpm update flag set without a completed division");

endmodule

@@ sim/tb_heartbeat_peak_detector_unit.sv @@
// Self-checking testbench for the heartbeat peak detector unit.
`timescale 1ns / 1ps

module tb_heartbeat_peak_detector_unit;

    localparam int HIST_DEPTH   = 10;
    localparam int LEVEL_W      = 12;
    localparam int LEVEL_MAX    = (1 << LEVEL_W) - 1;
    localparam int ELAPSED_MAX  = (1 << hpd_pkg::ELAPSED_W) - 1;
    localparam int AMP_RESET    = 100;
    localparam int IDLE_LIMIT   = 5000;  // cycles with no handshake at all
    localparam int DRAIN_CYCLES = 40;    // above the longest word latency with the result side open

    // result word, bpm in the low bits as on m_tdata
    typedef struct packed {
        logic [LEVEL_W-1:0]             threshold_now;
        logic [hpd_pkg::INTERVAL_W-1:0] interval_ms;
        logic                           in_pulse;
        logic                           bpm_updated;
        logic [hpd_pkg::BPM_W-1:0]      bpm;
    } beat_word_t;

    typedef enum logic { ROW_SAMPLE, ROW_WRITE } row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        hpd_pkg::cfg_reg_t  cfg_sel;
        logic [15:0]        value;
        logic               typed_in;  // result below is checked as written
        beat_word_t         result;
    } dir_row_t;

    typedef enum logic [1:0] { RX_OPEN, RX_SPARSE, RX_SQUARE, RX_STARVED } rx_mode_t;

    // result after reset while nothing has been detected yet
    localparam beat_word_t IDLE_WORD = '{
        threshold_now: 12'(hpd_pkg::LEVEL_RESET), interval_ms: 12'(hpd_pkg::INTERVAL_RESET),
        in_pulse: 1'b0, bpm_updated: 1'b0, bpm: 8'd0};

    localparam int N_DIRECTED = 24;
    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        '{ROW_SAMPLE, hpd_pkg::REG_TICK_MS, 16'd0, 1'b1, IDLE_WORD},
        '{ROW_SAMPLE, hpd_pkg::REG_TICK_MS, 16'd4095, 1'b1, IDLE_WORD}, // peak, refractory
        '{ROW_SAMPLE, hpd_pkg::REG_TICK_MS, 16'd512, 1'b1, IDLE_WORD},  // equal to threshold
        '{ROW_SAMPLE, hpd_pkg::REG_TICK_MS, 16'd513, 1'b1, IDLE_WORD},
        '{ROW_WRITE,  hpd_pkg::REG_TICK_MS, 16'd255, 1'b0, '0},
        '{ROW_WRITE,  hpd_pkg::REG_REFRACTORY_MS, 16'd0, 1'b0, '0},
        '{ROW_SAMPLE, hpd_pkg::REG_TICK_MS, 16'd4095, 1'b1, IDLE_WORD}, // before 3/5 interval
        '{ROW_SAMPLE, hpd_pkg::REG_TICK_MS, 16'd4095, 1'b0, '0},   // first beat, time only
        '{ROW_SAMPLE, hpd_pkg::REG_TICK_MS, 16'd0, 1'b0, '0},      // falling crossing
        '{ROW_SAMPLE, hpd_pkg::REG_TICK_MS, 16'd4095, 1'b0, '0},   // second beat fills history
        '{ROW_SAMPLE, hpd_pkg::REG_TICK_MS, 16'd0, 1'b0, '0},
        '{ROW_SAMPLE, hpd_pkg::REG_TICK_MS, 16'd4095, 1'b0, '0},
        '{ROW_SAMPLE, hpd_pkg::REG_TICK_MS, 16'd0, 1'b0, '0},
        '{ROW_SAMPLE, hpd_pkg::REG_TICK_MS, 16'd2048, 1'b0, '0},
        '{ROW_SAMPLE, hpd_pkg::REG_TICK_MS, 16'd4095, 1'b0, '0},
        '{ROW_WRITE,  hpd_pkg::REG_IDLE_LEVEL, 16'd4095, 1'b0, '0}, // waits for a timeout
        '{ROW_WRITE,  hpd_pkg::REG_TIMEOUT_MS, 16'd0, 1'b0, '0},
        '{ROW_SAMPLE, hpd_pkg::REG_TICK_MS, 16'd100, 1'b0, '0},    // timeout every tick
        '{ROW_SAMPLE, hpd_pkg::REG_TICK_MS, 16'd4095, 1'b0, '0},
        '{ROW_WRITE,  hpd_pkg::REG_TICK_MS, 16'd0, 1'b0, '0},      // elapsed frozen
        '{ROW_WRITE,  hpd_pkg::REG_TIMEOUT_MS, 16'd65535, 1'b0, '0},
        '{ROW_WRITE,  hpd_pkg::REG_IDLE_LEVEL, 16'd0, 1'b0, '0},
        '{ROW_SAMPLE, hpd_pkg::REG_TICK_MS, 16'd4095, 1'b0, '0},
        '{ROW_SAMPLE, hpd_pkg::REG_TICK_MS, 16'd0, 1'b0, '0}
    };

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    // detector shadow: config and state
    logic [7:0]  cfg_tick;
    logic [11:0] cfg_idle, cfg_refr;
    logic [15:0] cfg_timeout;
    int unsigned elapsed, last_ival, peak, trough, thr, ampl, bpm_val;
    int unsigned hist [HIST_DEPTH];
    bit          in_beat, want_first, want_second;

    beat_word_t  expected_q [$];
    int          err_count    = 0;
    int          words_sent   = 0;
    int          words_seen   = 0;
    int          n_settings   = 0;
    int          n_bpm        = 0;
    int          n_bpm_sat    = 0;
    int          n_first      = 0;
    int          n_timeout    = 0;
    int          burst_left   = 0;
    int          stall_cycles = 0;
    logic [7:0]  rx_tick      = '0;
    rx_mode_t    rx_mode      = RX_OPEN;

    heartbeat_peak_detector_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    function automatic void reset_detector_shadow();
        cfg_tick    = 8'(hpd_pkg::TICK_RESET);
        cfg_idle    = 12'(hpd_pkg::LEVEL_RESET);
        cfg_refr    = 12'(hpd_pkg::REFRACTORY_RESET);
        cfg_timeout = 16'(hpd_pkg::TIMEOUT_RESET);
        elapsed     = 0;
        last_ival   = hpd_pkg::INTERVAL_RESET;
        foreach (hist[i]) hist[i] = 0;
        peak        = hpd_pkg::LEVEL_RESET;
        trough      = hpd_pkg::LEVEL_RESET;
        thr         = hpd_pkg::LEVEL_RESET;
        ampl        = AMP_RESET;
        bpm_val     = 0;
        in_beat     = 1'b0;
        want_first  = 1'b1;
        want_second = 1'b1;
    endfunction

    // One tick of the detector: updates the shadow state, returns the result word.
    function automatic beat_word_t step_detector(input logic [LEVEL_W-1:0] level);
        int unsigned age, sum, avg, rate;
        bit          dicrotic, updated, first_only;
        beat_word_t  word;
        updated    = 1'b0;
        first_only = 1'b0;
        age = elapsed + cfg_tick;
        if (age > ELAPSED_MAX) age = ELAPSED_MAX;
        elapsed = age;
        // age before any beat is used for every test in this tick
        dicrotic = age > (last_ival / 5) * 3;

        if (level < thr && dicrotic && level < trough) trough = level;
        if (level > thr && level > peak) peak = level;

        if (age > cfg_refr && level > thr && !in_beat && dicrotic) begin
            in_beat   = 1'b1;
            last_ival = (age > hpd_pkg::MAX_INTERVAL) ? hpd_pkg::MAX_INTERVAL : age;
            elapsed   = 0;
            if (want_second) begin
                want_second = 1'b0;
                for (int i = 0; i < HIST_DEPTH; i++) hist[i] = last_ival;
            end
            if (want_first) begin
                // first beat after start or timeout: record time, skip the rest
                want_first  = 1'b0;
                want_second = 1'b1;
                first_only  = 1'b1;
                n_first++;
            end else begin
                sum = last_ival;
                for (int i = 0; i < HIST_DEPTH - 1; i++) begin
                    hist[i] = hist[i + 1];
                    sum += hist[i];
                end
                hist[HIST_DEPTH - 1] = last_ival;
                avg  = sum / HIST_DEPTH;
                rate = (avg == 0) ? hpd_pkg::BPM_MAX : hpd_pkg::MS_PER_MINUTE / avg;
                bpm_val = (rate > hpd_pkg::BPM_MAX) ? hpd_pkg::BPM_MAX : rate;
                updated = 1'b1;
                n_bpm++;
                if (bpm_val == hpd_pkg::BPM_MAX) n_bpm_sat++;
            end
        end

        if (!first_only) begin
            if (level < thr && in_beat) begin
                in_beat = 1'b0;
                ampl    = (peak - trough) & LEVEL_MAX;
                thr     = (ampl / 2 + trough) & LEVEL_MAX;
                peak    = thr;
                trough  = thr;
            end
            if (age > cfg_timeout) begin
                thr         = cfg_idle;
                peak        = cfg_idle;
                trough      = cfg_idle;
                elapsed     = 0;
                want_first  = 1'b1;
                want_second = 1'b0;
                n_timeout++;
            end
        end

        word.bpm           = hpd_pkg::BPM_W'(bpm_val);
        word.bpm_updated   = updated;
        word.in_pulse      = in_beat;
        word.interval_ms   = hpd_pkg::INTERVAL_W'(last_ival);
        word.threshold_now = LEVEL_W'(thr);
        return word;
    endfunction

    // Holds the sample stream off until every expected word has come back.
    task automatic wait_drained();
        s_tvalid  <= 1'b0;
        burst_left = 0;
        while (expected_q.size() != 0) @(posedge aclk);
    endtask

    // Caller makes sure the block is drained; valid stays up within a batch.
    task automatic write_register(input hpd_pkg::cfg_reg_t sel, input logic [15:0] val,
                                  input bit last_in_batch);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (sel)
            hpd_pkg::REG_TICK_MS:       cfg_tick    = val[7:0];
            hpd_pkg::REG_IDLE_LEVEL:    cfg_idle    = val[11:0];
            hpd_pkg::REG_REFRACTORY_MS: cfg_refr    = val[11:0];
            hpd_pkg::REG_TIMEOUT_MS:    cfg_timeout = val;
            default: ;
        endcase
        if (last_in_batch) cfg_valid <= 1'b0;
    endtask

    // Sends one sample word in a burst/gap pattern; queues the typed-in or predicted word.
    task automatic feed_sample(input logic [LEVEL_W-1:0] level, input bit typed_in,
                               input beat_word_t typed_word);
        int         gap;
        beat_word_t predicted;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, level};
        do @(posedge aclk); while (!s_tready);
        predicted = step_detector(level);
        expected_q.push_back(typed_in ? typed_word : predicted);
        words_sent++;
    endtask

    // One register setting followed by shaped samples: mostly pulse trains,
    // some flat stretches (elapsed saturation) and some raw noise.
    task automatic run_phase(input logic [7:0] tick, input logic [11:0] idle,
                             input logic [11:0] refr, input logic [15:0] tmo,
                             input int n_items, input int flat_len);
        int done, pick, period, duty, hi, lo, seg_len, v;
        done = 0;
        wait_drained();
        write_register(hpd_pkg::REG_TICK_MS,       16'(tick), 1'b0);
        write_register(hpd_pkg::REG_IDLE_LEVEL,    16'(idle), 1'b0);
        write_register(hpd_pkg::REG_REFRACTORY_MS, 16'(refr), 1'b0);
        write_register(hpd_pkg::REG_TIMEOUT_MS,    tmo,       1'b1);
        n_settings++;
        for (int k = 0; k < flat_len; k++) begin
            feed_sample('0, 1'b0, '0);
            done++;
        end
        while (done < n_items) begin
            if ($urandom_range(0, 49) == 0) wait_drained();
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                v       = $urandom_range(0, 1500);
                seg_len = $urandom_range(20, 300);
                for (int k = 0; k < seg_len && done < n_items; k++) begin
                    feed_sample(LEVEL_W'(v), 1'b0, '0);
                    done++;
                end
            end else if (pick == 1) begin
                seg_len = $urandom_range(5, 30);
                for (int k = 0; k < seg_len && done < n_items; k++) begin
                    feed_sample(LEVEL_W'($urandom_range(0, LEVEL_MAX)), 1'b0, '0);
                    done++;
                end
            end else begin
                period  = $urandom_range(2, 40);
                duty    = $urandom_range(1, period - 1);
                hi      = $urandom_range(2000, LEVEL_MAX);
                lo      = $urandom_range(0, 1800);
                seg_len = period * $urandom_range(2, 12);
                for (int k = 0; k < seg_len && done < n_items; k++) begin
                    v = ((k % period) < duty) ? hi : lo;
                    v = v + int'($urandom_range(0, 64)) - 32;
                    if (v < 0) v = 0;
                    if (v > LEVEL_MAX) v = LEVEL_MAX;
                    feed_sample(LEVEL_W'(v), 1'b0, '0);
                    done++;
                end
            end
        end
    endtask

    // receiver: stall pattern changes each time rx_tick wraps to zero
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_tick  <= '0;
            rx_mode  <= RX_OPEN;
        end else begin
            rx_tick <= rx_tick + 8'd1;
            if (rx_tick == 8'd0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
            case (rx_mode)
                RX_OPEN:    m_tready <= 1'b1;
                RX_SPARSE:  m_tready <= ($urandom_range(0, 3) != 0);
                RX_SQUARE:  m_tready <= rx_tick[3];
                RX_STARVED: m_tready <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    // result checker: oldest expectation against each accepted word
    always @(posedge aclk) begin : result_check
        beat_word_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(beat_word_t)-1:0];
            words_seen++;
            if (expected_q.size() == 0) begin
                err_count++;
                $display("%0t: result word with nothing expected, got %h", $time, got);
            end else begin
                want = expected_q.pop_front();
                if (got.bpm != want.bpm) begin
                    err_count++;
                    $display("%0t: bpm expected %0d, got %0d", $time, want.bpm, got.bpm);
                end
                if (got.bpm_updated != want.bpm_updated) begin
                    err_count++;
                    $display("%0t: bpm_updated expected %0d, got %0d",
                             $time, want.bpm_updated, got.bpm_updated);
                end
                if (got.in_pulse != want.in_pulse) begin
                    err_count++;
                    $display("%0t: in_pulse expected %0d, got %0d",
                             $time, want.in_pulse, got.in_pulse);
                end
                if (got.interval_ms != want.interval_ms) begin
                    err_count++;
                    $display("%0t: interval_ms expected %0d, got %0d",
                             $time, want.interval_ms, got.interval_ms);
                end
                if (got.threshold_now != want.threshold_now) begin
                    err_count++;
                    $display("%0t: threshold_now expected %0d, got %0d",
                             $time, want.threshold_now, got.threshold_now);
                end
            end
        end
    end

    // watchdog: ends the run if no channel moves a word for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == IDLE_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d words outstanding",
                         $time, IDLE_LIMIT, expected_q.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [7:0]  r_tick;
        logic [11:0] r_idle, r_refr;
        logic [15:0] r_tmo;
        reset_detector_shadow();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows under reset defaults, then a few register corners
        for (int i = 0; i < N_DIRECTED; i++) begin
            if (DIRECTED[i].kind == ROW_WRITE) begin
                wait_drained();
                write_register(DIRECTED[i].cfg_sel, DIRECTED[i].value,
                               i + 1 == N_DIRECTED || DIRECTED[i + 1].kind != ROW_WRITE);
            end else begin
                feed_sample(DIRECTED[i].value[LEVEL_W-1:0], DIRECTED[i].typed_in,
                            DIRECTED[i].result);
            end
        end

        run_phase(8'd40,  12'd512,  12'd250,  16'd2500,  250, 0);
        // no timeout possible: elapsed saturates, next beat has the maximum interval
        run_phase(8'd255, 12'd0,    12'd0,    16'd65535, 400, 280);
        // timeout on every tick, refractory never passed
        run_phase(8'd1,   12'd4095, 12'd4095, 16'd0,     40,  0);
        // very short intervals: BPM saturates
        run_phase(8'd1,   12'd2048, 12'd0,    16'd65535, 150, 0);
        for (int p = 0; p < 6; p++) begin
            r_tick = 8'($urandom_range(1, 255));
            r_idle = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, LEVEL_MAX))
                                                 : 12'($urandom_range(0, 2500));
            r_refr = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, LEVEL_MAX))
                                                 : 12'($urandom_range(0, 400));
            r_tmo  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, ELAPSED_MAX))
                                                 : 16'($urandom_range(800, 4000));
            run_phase(r_tick, r_idle, r_refr, r_tmo, 145, 0);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d sample words over %0d register settings, %0d result words checked",
                 words_sent, n_settings + 1, words_seen);
        $display("Seen: %0d BPM updates (%0d at 255), %0d first beats, %0d timeouts",
                 n_bpm, n_bpm_sat, n_first, n_timeout);
        if (err_count == 0 && expected_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
